// File: hw/rtl/eodm_pkg.sv
package eodm_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int PT_BITS = 22;

    localparam logic [15:0] RATIO_MAX_RST = 16'd16384;
    localparam logic [15:0] RATIO_MIN_RST = 16'd0;
    localparam logic [6:0] LIMIT_RST = 7'd80;
    localparam logic [7:0] RUN_RST = 8'd20;

    localparam logic [1:0] REG_MAX = 2'd0;
    localparam logic [1:0] REG_MIN = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;
    localparam logic [1:0] REG_RUN = 2'd3;

    typedef struct packed {
        logic [PT_BITS-1:0] left_eye_pt0;
        logic [PT_BITS-1:0] left_eye_pt1;
        logic [PT_BITS-1:0] left_eye_pt2;
        logic [PT_BITS-1:0] left_eye_pt3;
        logic [PT_BITS-1:0] left_eye_pt4;
        logic [PT_BITS-1:0] left_eye_pt5;
        logic [PT_BITS-1:0] right_eye_pt0;
        logic [PT_BITS-1:0] right_eye_pt1;
        logic [PT_BITS-1:0] right_eye_pt2;
        logic [PT_BITS-1:0] right_eye_pt3;
        logic [PT_BITS-1:0] right_eye_pt4;
        logic [PT_BITS-1:0] right_eye_pt5;
    } in_item_t;

    typedef struct packed {
        logic [15:0] aspect_ratio;
        logic signed [15:0] open_percent;
        logic [7:0] low_run;
        logic drowsy_alarm;
        logic range_error;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic eye_sel;
        logic geo;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic eye_store;
        logic pct_start;
        logic pct_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic pct_done;
    } status_t;

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_GEO = 11'b00000000010,
        ST_DSTART = 11'b00000000100,
        ST_DIV = 11'b00000001000,
        ST_SSTART = 11'b00000010000,
        ST_SQRT = 11'b00000100000,
        ST_STORE = 11'b00001000000,
        ST_PSTART = 11'b00010000000,
        ST_PCT = 11'b00100000000,
        ST_FIN = 11'b01000000000,
        ST_OUT = 11'b10000000000
    } state_t;

endpackage

// File: hw/rtl/eodm_ctrl.sv
module eodm_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  eodm_pkg::status_t status,
    output eodm_pkg::cmd_t cmd
);

    eodm_pkg::state_t state_reg, state_next;
    logic eye_reg, eye_next;

    assign in_ready = (state_reg == eodm_pkg::ST_IDLE);
    assign out_valid = (state_reg == eodm_pkg::ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        eye_next = eye_reg;
        cmd = '0;
        cmd.eye_sel = eye_reg;
        case (state_reg)
            eodm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    eye_next = 1'b0;
                    state_next = eodm_pkg::ST_GEO;
                end
            end
            eodm_pkg::ST_GEO:
            begin
                cmd.geo = 1'b1;
                state_next = eodm_pkg::ST_DSTART;
            end
            eodm_pkg::ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next = eodm_pkg::ST_DIV;
            end
            eodm_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                    state_next = eodm_pkg::ST_SSTART;
            end
            eodm_pkg::ST_SSTART:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = eodm_pkg::ST_SQRT;
            end
            eodm_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                    state_next = eodm_pkg::ST_STORE;
            end
            eodm_pkg::ST_STORE:
            begin
                cmd.eye_store = 1'b1;
                if (eye_reg)
                    state_next = eodm_pkg::ST_PSTART;
                else
                begin
                    eye_next = 1'b1;
                    state_next = eodm_pkg::ST_GEO;
                end
            end
            eodm_pkg::ST_PSTART:
            begin
                cmd.pct_start = 1'b1;
                state_next = eodm_pkg::ST_PCT;
            end
            eodm_pkg::ST_PCT:
            begin
                cmd.pct_step = 1'b1;
                if (status.pct_done)
                    state_next = eodm_pkg::ST_FIN;
            end
            eodm_pkg::ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = eodm_pkg::ST_OUT;
            end
            eodm_pkg::ST_OUT:
            begin
                if (out_ready)
                    state_next = eodm_pkg::ST_IDLE;
            end
            default: state_next = eodm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eodm_pkg::ST_IDLE;
            eye_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eye_reg <= eye_next;
        end
    end

endmodule

// File: hw/rtl/eodm_datapath.sv
module eodm_datapath (
    input  logic clk,
    input  logic rst_n,
    input  eodm_pkg::in_item_t in_item,
    input  eodm_pkg::cmd_t cmd,
    output eodm_pkg::status_t status,
    input  logic [15:0] ratio_max,
    input  logic [15:0] ratio_min,
    input  logic [6:0] limit,
    input  logic [7:0] run_len,
    output eodm_pkg::out_item_t out_item
);

    localparam int CB = eodm_pkg::COORD_BITS_DEF;
    localparam int D2 = 2 * CB + 1;          // width of a squared distance sum
    localparam int NUMW = D2 + 28;           // dividend width
    localparam int QW = NUMW;                // quotient width
    localparam int SW = (QW + 1) / 2;        // root width
    localparam int DCW = $clog2(QW + 1);
    localparam int SCW = $clog2(SW + 1);

    eodm_pkg::in_item_t pts_reg;
    logic [D2-1:0] v2_reg, h2_reg;
    logic h2z_reg;

    logic [QW-1:0] quo_reg, quo_next;
    logic [D2:0] rem_reg, rem_next;
    logic [DCW-1:0] dcnt_reg;

    logic [QW+1:0] srem_reg, srem_next;
    logic [SW-1:0] root_reg, root_next;
    logic [2*SW-1:0] sval_reg;
    logic [SCW-1:0] scnt_reg;

    logic [15:0] left_reg;
    logic [15:0] ratio_reg;

    // Percent divider: |diff*6400| by |span|, restoring, 30 bits.
    localparam int PNW = 30;
    logic [PNW-1:0] pq_reg, pq_next;
    logic [16:0] pr_reg, pr_next;
    logic [4:0] pcnt_reg;
    logic signed [17:0] diff_reg, span_reg;
    logic [16:0] aspan_reg;

    logic [7:0] run_reg;
    eodm_pkg::out_item_t out_reg;

    function automatic logic [CB-1:0] cx(input logic [eodm_pkg::PT_BITS-1:0] p);
        cx = p[CB-1:0];
    endfunction
    function automatic logic [CB-1:0] cy(input logic [eodm_pkg::PT_BITS-1:0] p);
        cy = p[2*CB-1:CB];
    endfunction

    logic [eodm_pkg::PT_BITS-1:0] p0, p1, p2, p3, p4, p5;
    logic [CB:0] sx_u, sy_u, sx_l, sy_l;
    logic signed [CB+1:0] vx, vy, hx, hy;
    logic [D2-1:0] v2_c, h2_c;

    always_comb
    begin
        if (cmd.eye_sel)
        begin
            p0 = pts_reg.right_eye_pt0; p1 = pts_reg.right_eye_pt1;
            p2 = pts_reg.right_eye_pt2; p3 = pts_reg.right_eye_pt3;
            p4 = pts_reg.right_eye_pt4; p5 = pts_reg.right_eye_pt5;
        end
        else
        begin
            p0 = pts_reg.left_eye_pt0; p1 = pts_reg.left_eye_pt1;
            p2 = pts_reg.left_eye_pt2; p3 = pts_reg.left_eye_pt3;
            p4 = pts_reg.left_eye_pt4; p5 = pts_reg.left_eye_pt5;
        end
        sx_u = {1'b0, cx(p1)} + {1'b0, cx(p2)};
        sy_u = {1'b0, cy(p1)} + {1'b0, cy(p2)};
        sx_l = {1'b0, cx(p4)} + {1'b0, cx(p5)};
        sy_l = {1'b0, cy(p4)} + {1'b0, cy(p5)};
        vx = $signed({2'b00, sx_u[CB:1]}) - $signed({2'b00, sx_l[CB:1]});
        vy = $signed({2'b00, sy_u[CB:1]}) - $signed({2'b00, sy_l[CB:1]});
        hx = $signed({2'b00, cx(p0)}) - $signed({2'b00, cx(p3)});
        hy = $signed({2'b00, cy(p0)}) - $signed({2'b00, cy(p3)});
        v2_c = D2'(vx * vx) + D2'(vy * vy);
        h2_c = D2'(hx * hx) + D2'(hy * hy);
    end

    // Restoring divide of (v2 << 28) by h2, one quotient bit per cycle.
    logic [D2:0] rtry;
    logic [D2+1:0] rsub;
    always_comb
    begin
        rtry = {rem_reg[D2-1:0], quo_reg[QW-1]};
        rsub = {1'b0, rtry} - {2'b00, h2_reg};
        quo_next = {quo_reg[QW-2:0], ~rsub[D2+1]};
        rem_next = rsub[D2+1] ? rtry : rsub[D2:0];
    end

    // Integer square root, two radicand bits per cycle.
    logic [QW+1:0] strial;
    logic [QW+1:0] sshift;
    always_comb
    begin
        sshift = {srem_reg[QW-1:0], sval_reg[2*SW-1 -: 2]};
        strial = (QW+2)'({root_reg, 2'b01});
        if (sshift >= strial)
        begin
            srem_next = sshift - strial;
            root_next = {root_reg[SW-2:0], 1'b1};
        end
        else
        begin
            srem_next = sshift;
            root_next = {root_reg[SW-2:0], 1'b0};
        end
    end

    logic [15:0] eye_ratio;
    assign eye_ratio = h2z_reg ? 16'hFFFF :
                       ((|root_reg[SW-1:16]) ? 16'hFFFF : root_reg[15:0]);

    logic [16:0] pr_try;
    logic [17:0] pr_sub;
    always_comb
    begin
        pr_try = {pr_reg[15:0], pq_reg[PNW-1]};
        pr_sub = {1'b0, pr_try} - {1'b0, aspan_reg};
        pq_next = {pq_reg[PNW-2:0], ~pr_sub[17]};
        pr_next = pr_sub[17] ? pr_try : pr_sub[16:0];
    end

    logic signed [17:0] diff_c, span_c;
    logic [16:0] adiff_c;
    logic signed [31:0] pct_s;
    logic signed [15:0] pct_sat;
    logic signed [26:0] lhs, rhs;
    logic low, rerr;
    logic neg;
    always_comb
    begin
        diff_c = $signed({2'b00, ratio_reg}) - $signed({2'b00, ratio_min});
        span_c = $signed({2'b00, ratio_max}) - $signed({2'b00, ratio_min});
        adiff_c = diff_c[17] ? 17'(-diff_c) : diff_c[16:0];
        neg = diff_reg[17] ^ span_reg[17];
        pct_s = neg ? -$signed({2'b00, pq_reg}) : $signed({2'b00, pq_reg});
        if (pct_s > 32'sd32767)
            pct_sat = 16'sh7FFF;
        else if (pct_s < -32'sd32768)
            pct_sat = 16'sh8000;
        else
            pct_sat = pct_s[15:0];
        rerr = (span_reg == 18'sd0);
        lhs = 27'(diff_reg * 18'sd100);
        rhs = 27'(span_reg * $signed({11'd0, limit}));
        if (rerr)
            low = 1'b1;
        else if (!span_reg[17])
            low = (lhs <= rhs);
        else
            low = (lhs >= rhs);
    end

    assign status.div_done = (dcnt_reg == DCW'(QW - 1));
    assign status.sqrt_done = (scnt_reg == SCW'(SW - 1));
    assign status.pct_done = (pcnt_reg == 5'(PNW - 1));

    logic [16:0] sum_lr;
    assign sum_lr = {1'b0, left_reg} + {1'b0, eye_ratio};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pts_reg <= in_item;
        if (cmd.geo)
        begin
            v2_reg <= v2_c;
            h2_reg <= h2_c;
            h2z_reg <= (h2_c == '0);
        end
        if (cmd.div_start)
        begin
            quo_reg <= {v2_reg, 28'd0};
            rem_reg <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.sqrt_start)
        begin
            // The radicand is widened to an even number of bits.
            sval_reg <= (2*SW)'(quo_reg);
            srem_reg <= '0;
            root_reg <= '0;
            scnt_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sval_reg <= {sval_reg[2*SW-3:0], 2'b00};
            srem_reg <= srem_next;
            root_reg <= root_next;
            scnt_reg <= scnt_reg + 1'b1;
        end
        if (cmd.eye_store)
        begin
            if (cmd.eye_sel)
                ratio_reg <= sum_lr[16:1];
            else
                left_reg <= eye_ratio;
        end
        if (cmd.pct_start)
        begin
            diff_reg <= diff_c;
            span_reg <= span_c;
            aspan_reg <= span_c[17] ? 17'(-span_c) : span_c[16:0];
            pq_reg <= PNW'(adiff_c * 13'd6400);
            pr_reg <= '0;
            pcnt_reg <= '0;
        end
        else if (cmd.pct_step)
        begin
            pq_reg <= pq_next;
            pr_reg <= pr_next;
            pcnt_reg <= pcnt_reg + 1'b1;
        end
    end

    logic [7:0] run_new;
    assign run_new = low ? ((run_reg == 8'hFF) ? run_reg : run_reg + 8'd1) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_reg <= '0;
        else if (cmd.finish)
            run_reg <= run_new;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg.aspect_ratio <= ratio_reg;
            out_reg.open_percent <= rerr ? 16'sd0 : pct_sat;
            out_reg.low_run <= run_new;
            out_reg.drowsy_alarm <= (run_new > run_len);
            out_reg.range_error <= rerr;
        end
    end

    assign out_item = out_reg;

endmodule

// File: hw/rtl/eye_openness_drowsiness_monitor_unit.sv
// Eye openness drowsiness monitor.
// Input channel (in_valid/in_ready/in_data) carries one request with twelve
// packed eye landmarks; output channel (out_valid/out_ready/out_data) returns
// one result per request: mean eye aspect ratio, openness percent, low run
// count, alarm and calibration range error.
// One request is processed at a time. For each eye a bit-serial divider runs
// one quotient bit per cycle followed by a square root unit at one root bit
// per cycle, framed by geometry, start and store steps; the percent stage
// follows both eyes. out_valid rises after the percent stage, and a new
// request can be accepted only once the previous result has been taken.
// in_ready is high only while the block is idle. If the receiver stalls,
// the result is held in the output register and no new request is taken.
// Reset clears the controller, the low run count and restores the
// calibration registers; APB writes are accepted at any time but should be
// made while idle.
module eye_openness_drowsiness_monitor_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  eodm_pkg::in_item_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output eodm_pkg::out_item_t out_data,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [3:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);

    logic [15:0] max_reg, min_reg;
    logic [6:0] limit_reg;
    logic [7:0] run_reg;
    eodm_pkg::cmd_t cmd;
    eodm_pkg::status_t status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= eodm_pkg::RATIO_MAX_RST;
            min_reg <= eodm_pkg::RATIO_MIN_RST;
            limit_reg <= eodm_pkg::LIMIT_RST;
            run_reg <= eodm_pkg::RUN_RST;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                eodm_pkg::REG_MAX: max_reg <= pwdata[15:0];
                eodm_pkg::REG_MIN: min_reg <= pwdata[15:0];
                eodm_pkg::REG_LIMIT: limit_reg <= pwdata[6:0];
                eodm_pkg::REG_RUN: run_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            eodm_pkg::REG_MAX: prdata = {16'd0, max_reg};
            eodm_pkg::REG_MIN: prdata = {16'd0, min_reg};
            eodm_pkg::REG_LIMIT: prdata = {25'd0, limit_reg};
            eodm_pkg::REG_RUN: prdata = {24'd0, run_reg};
            default: prdata = '0;
        endcase
    end

    eodm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .cmd(cmd)
    );

    eodm_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .status(status),
        .ratio_max(max_reg), .ratio_min(min_reg),
        .limit(limit_reg), .run_len(run_reg),
        .out_item(out_data)
    );

endmodule

// File: test/eye_openness_drowsiness_monitor_unit_tb.sv
module eye_openness_drowsiness_monitor_unit_tb;

    localparam int CB = eodm_pkg::COORD_BITS_DEF;
    localparam int PB = eodm_pkg::PT_BITS;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    eodm_pkg::in_item_t in_data;
    logic out_valid;
    logic out_ready;
    eodm_pkg::out_item_t out_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    eye_openness_drowsiness_monitor_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Calibration and run state mirrored by the predictor.
    logic [15:0] cal_max;
    logic [15:0] cal_min;
    logic [6:0] cal_limit;
    logic [7:0] cal_run;
    logic [7:0] pred_run;

    eodm_pkg::in_item_t frame_q[$];
    eodm_pkg::out_item_t result_q[$];
    int mismatches;
    int results_seen;
    int alarms_seen;
    int range_errs_seen;
    int idle_cycles;
    int send_gap;
    int stall_hold;
    bit long_stall_req;
    bit long_stall_done;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [63:0] root64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint px(input logic [PB-1:0] p);
        return longint'(p[CB-1:0]);
    endfunction

    function automatic longint py(input logic [PB-1:0] p);
        return longint'(p[2*CB-1:CB]);
    endfunction

    function automatic logic [63:0] eye_ar(input logic [PB-1:0] c0, u1, u2, c3, l4, l5);
        longint vx, vy, hx, hy;
        logic [63:0] v2, h2, r;
        vx = ((px(u1) + px(u2)) >>> 1) - ((px(l4) + px(l5)) >>> 1);
        vy = ((py(u1) + py(u2)) >>> 1) - ((py(l4) + py(l5)) >>> 1);
        hx = px(c0) - px(c3);
        hy = py(c0) - py(c3);
        v2 = vx * vx + vy * vy;
        h2 = hx * hx + hy * hy;
        if (h2 == 0) return 64'd65535;
        r = root64((v2 << 28) / h2);
        return (r > 65535) ? 64'd65535 : r;
    endfunction

    function automatic eodm_pkg::out_item_t predict_frame(input eodm_pkg::in_item_t f);
        eodm_pkg::out_item_t o;
        logic [63:0] ratio;
        longint diff, span, lim, pct;
        bit low;
        ratio = (eye_ar(f.left_eye_pt0, f.left_eye_pt1, f.left_eye_pt2, f.left_eye_pt3,
                        f.left_eye_pt4, f.left_eye_pt5) +
                 eye_ar(f.right_eye_pt0, f.right_eye_pt1, f.right_eye_pt2, f.right_eye_pt3,
                        f.right_eye_pt4, f.right_eye_pt5)) >> 1;
        diff = longint'(ratio) - longint'(cal_min);
        span = longint'(cal_max) - longint'(cal_min);
        lim = longint'(cal_limit);
        pct = 0;
        if (span == 0)
        begin
            low = 1'b1;
        end
        else
        begin
            pct = (diff * 6400) / span;
            if (pct > 32767) pct = 32767;
            if (pct < -32768) pct = -32768;
            if (span > 0) low = (diff * 100 <= lim * span);
            else low = (diff * 100 >= lim * span);
        end
        if (low)
        begin
            if (pred_run != 8'd255) pred_run = pred_run + 8'd1;
        end
        else
        begin
            pred_run = 8'd0;
        end
        o.aspect_ratio = ratio[15:0];
        o.open_percent = pct[15:0];
        o.low_run = pred_run;
        o.drowsy_alarm = (pred_run > cal_run);
        o.range_error = (span == 0);
        return o;
    endfunction

    function automatic logic [PB-1:0] mk_pt(input int x, input int y);
        return PB'((y << CB) | x);
    endfunction

    function automatic logic [PB-1:0] rnd_pt();
        return PB'($urandom);
    endfunction

    // A plausible eye: corners apart horizontally, lids around the center line.
    function automatic eodm_pkg::in_item_t eye_frame(input int open_l, input int open_r);
        eodm_pkg::in_item_t f;
        int cx, cy, w;
        cx = $urandom_range(200, 1800);
        cy = $urandom_range(200, 1800);
        w = $urandom_range(1, 150);
        f.left_eye_pt0 = mk_pt(cx - w, cy + $urandom_range(0, 4));
        f.left_eye_pt3 = mk_pt(cx + w, cy);
        f.left_eye_pt1 = mk_pt(cx - w / 3, cy - open_l);
        f.left_eye_pt2 = mk_pt(cx + w / 3, cy - open_l - $urandom_range(0, 2));
        f.left_eye_pt4 = mk_pt(cx - w / 3, cy + open_l);
        f.left_eye_pt5 = mk_pt(cx + w / 3, cy + open_l + $urandom_range(0, 2));
        cx = cx - $urandom_range(0, 150) + 75;
        f.right_eye_pt0 = mk_pt(cx - w, cy);
        f.right_eye_pt3 = mk_pt(cx + w, cy + $urandom_range(0, 4));
        f.right_eye_pt1 = mk_pt(cx - w / 3, cy - open_r);
        f.right_eye_pt2 = mk_pt(cx + w / 3, cy - open_r);
        f.right_eye_pt4 = mk_pt(cx - w / 3, cy + open_r);
        f.right_eye_pt5 = mk_pt(cx + w / 3, cy + open_r + $urandom_range(0, 1));
        // The top bit of these two points is the y coordinate MSB and is randomized.
        f.left_eye_pt1[PB-1] = $urandom_range(0, 1);
        f.right_eye_pt4[PB-1] = $urandom_range(0, 1);
        return f;
    endfunction

    function automatic eodm_pkg::in_item_t noise_frame();
        eodm_pkg::in_item_t f;
        f = {rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(),
             rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt(), rnd_pt()};
        return f;
    endfunction

    // Driver: bursts of requests with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                result_q = {result_q, predict_frame(in_data)};
                frame_q.delete(0);
            end
            if (in_valid && !in_ready)
            begin
                // Hold the request until it is accepted.
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (frame_q.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data <= frame_q[0];
                if ($urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 300);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: result check and receiver stall pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_hold <= 0;
            long_stall_done <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (result_q.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %p", out_data);
                end
                else
                begin
                    if (out_data !== result_q[0])
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p got %p", result_q[0], out_data);
                    end
                    if (out_data.drowsy_alarm) alarms_seen <= alarms_seen + 1;
                    if (out_data.range_error) range_errs_seen <= range_errs_seen + 1;
                    result_q.delete(0);
                end
            end
            if (long_stall_req && !long_stall_done)
            begin
                out_ready <= 1'b0;
                long_stall_done <= 1'b1;
                stall_hold <= 3000;
            end
            else if (stall_hold > 0)
            begin
                out_ready <= 1'b0;
                stall_hold <= stall_hold - 1;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0: stall_hold <= $urandom_range(1, 400);
                    1, 2: out_ready <= 1'b0;
                    default: out_ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress, %0d results pending", result_q.size());
            $display("eye_openness_drowsiness_monitor_unit test failed");
            $finish;
        end
    end

    task automatic add_frame(input eodm_pkg::in_item_t f);
        frame_q = {frame_q, f};
    endtask

    task automatic wait_drained();
        while (frame_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
        repeat (250) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            eodm_pkg::REG_MAX: cal_max = val[15:0];
            eodm_pkg::REG_MIN: cal_min = val[15:0];
            eodm_pkg::REG_LIMIT: cal_limit = val[6:0];
            eodm_pkg::REG_RUN: cal_run = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_cal(input int mx, input int mn, input int lim, input int run);
        reg_write(eodm_pkg::REG_MAX, 32'(mx));
        reg_write(eodm_pkg::REG_MIN, 32'(mn));
        reg_write(eodm_pkg::REG_LIMIT, 32'(lim));
        reg_write(eodm_pkg::REG_RUN, 32'(run));
    endtask

    task automatic queue_random(input int n);
        int o;
        for (int i = 0; i < n; i++)
        begin
            o = $urandom_range(0, 99);
            if (o < 15) add_frame(noise_frame());
            else if (o < 55) add_frame(eye_frame($urandom_range(0, 3), $urandom_range(0, 3)));
            else add_frame(eye_frame($urandom_range(0, 60), $urandom_range(0, 60)));
        end
    endtask

    initial
    begin
        eodm_pkg::in_item_t f;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        results_seen = 0;
        alarms_seen = 0;
        range_errs_seen = 0;
        idle_cycles = 0;
        long_stall_req = 1'b0;
        cal_max = eodm_pkg::RATIO_MAX_RST;
        cal_min = eodm_pkg::RATIO_MIN_RST;
        cal_limit = eodm_pkg::LIMIT_RST;
        cal_run = eodm_pkg::RUN_RST;
        pred_run = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames under reset calibration.
        f = '0;
        add_frame(f);
        f = '1;
        add_frame(f);
        f = '0;
        f.left_eye_pt3 = mk_pt(2047, 0);
        f.left_eye_pt1 = mk_pt(0, 2047);
        f.left_eye_pt2 = mk_pt(0, 2047);
        f.right_eye_pt3 = mk_pt(2047, 2047);
        f.right_eye_pt4 = mk_pt(2047, 2047);
        f.right_eye_pt5 = mk_pt(2047, 2047);
        add_frame(f);
        f = '0;
        f.left_eye_pt3 = mk_pt(1, 0);
        f.left_eye_pt1 = mk_pt(0, 2047);
        f.left_eye_pt2 = mk_pt(0, 2047);
        f.right_eye_pt3 = mk_pt(0, 1);
        f.right_eye_pt4 = mk_pt(2047, 2047);
        f.right_eye_pt5 = mk_pt(2047, 2047);
        add_frame(f);
        for (int i = 0; i < 6; i++) add_frame(eye_frame(0, 0));
        for (int i = 0; i < 4; i++) add_frame(eye_frame(40, 40));
        wait_drained();

        // Equal calibration, range error with a growing run and a short alarm length.
        set_cal(5000, 5000, 0, 0);
        for (int i = 0; i < 4; i++) add_frame(eye_frame(30, 30));
        wait_drained();
        // Inverted calibration, limit above one hundred.
        set_cal(0, 65535, 127, 255);
        for (int i = 0; i < 5; i++) add_frame(eye_frame($urandom_range(0, 60), 20));
        wait_drained();
        set_cal(65535, 0, 100, 3);
        for (int i = 0; i < 4; i++) add_frame(noise_frame());
        wait_drained();

        // Random phases over several calibrations.
        set_cal(16384, 0, 80, 20);
        queue_random(200);
        long_stall_req = 1'b1;
        wait_drained();
        set_cal(5000, 5000, 50, 255);
        queue_random(280);
        wait_drained();
        set_cal(1000, 12000, $urandom_range(0, 127), $urandom_range(0, 255));
        queue_random(100);
        wait_drained();
        set_cal($urandom_range(0, 65535), $urandom_range(0, 65535),
                $urandom_range(0, 127), $urandom_range(0, 255));
        queue_random(100);
        wait_drained();
        set_cal(4000 + $urandom_range(0, 4000), $urandom_range(0, 2000), 30, 5);
        queue_random(120);
        wait_drained();

        $display("covered %0d frames across extreme, equal and inverted calibrations",
                 results_seen);
        $display("%0d alarm results, %0d range error results, %0d mismatches",
                 alarms_seen, range_errs_seen, mismatches);
        if (mismatches == 0 && result_q.size() == 0)
        begin
            $display("eye_openness_drowsiness_monitor_unit test passed");
        end
        else
        begin
            $display("eye_openness_drowsiness_monitor_unit test failed");
        end
        $finish;
    end

endmodule
